/* rtl/tecq_pkg.sv */
// types and constants shared by the touch event classifier queue
`default_nettype none

package tecq_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CODE_POS_X = 2'd0;
  localparam logic [1:0] CFG_CODE_POS_Y = 2'd1;
  localparam logic [1:0] CFG_CODE_TOUCH = 2'd2;

  localparam logic [15:0] CODE_POS_X_RST = 16'd0;
  localparam logic [15:0] CODE_POS_Y_RST = 16'd1;
  localparam logic [15:0] CODE_TOUCH_RST = 16'd330;

  localparam logic [15:0] COORD_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic               sync;
  } in_item_t;

  typedef struct packed {
    logic        queued;
    logic        dropped;
    logic        out_valid;
    logic [1:0]  out_kind;
    logic [15:0] out_x;
    logic [15:0] out_y;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/tecq_ctrl.sv */
// controller state machine sequencing one item at a time
`default_nettype none

module tecq_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  tecq_pkg::dp_status_t   status_i,
  output tecq_pkg::ctrl_cmd_t    cmd_o
);

  tecq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tecq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      tecq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tecq_pkg::ST_EXEC;
        end
      end
      tecq_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        // a pop goes on to ST_READ to capture the registered memory read
        state_d    = status_i.is_pop ? tecq_pkg::ST_READ : tecq_pkg::ST_HOLD;
      end
      tecq_pkg::ST_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = tecq_pkg::ST_HOLD;
      end
      tecq_pkg::ST_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = tecq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tecq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/tecq_dp.sv */
// datapath: config registers, position and press state, ring queue memory
`default_nettype none

module tecq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  tecq_pkg::ctrl_cmd_t    cmd_i,
  output tecq_pkg::dp_status_t   status_o,
  input  tecq_pkg::in_item_t     in_data_i,
  input  wire                    cfg_we_i,
  input  wire  [1:0]             cfg_idx_i,
  input  wire  [15:0]            cfg_data_i,
  output tecq_pkg::out_item_t    out_data_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] idx);
    next_slot = (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  logic [15:0] code_x_q, code_y_q, code_t_q;
  logic [15:0] pos_x_q, pos_y_q;
  logic        pressed_q;
  logic [IdxW-1:0] wr_q, rd_q;
  logic        hit_q;
  tecq_pkg::in_item_t  item_q;
  tecq_pkg::entry_t    rdata_q;
  tecq_pkg::out_item_t res_q, res_d;
  tecq_pkg::entry_t    mem [QUEUE_DEPTH];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_x_q <= tecq_pkg::CODE_POS_X_RST;
      code_y_q <= tecq_pkg::CODE_POS_Y_RST;
      code_t_q <= tecq_pkg::CODE_TOUCH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tecq_pkg::CFG_CODE_POS_X: code_x_q <= cfg_data_i;
        tecq_pkg::CFG_CODE_POS_Y: code_y_q <= cfg_data_i;
        tecq_pkg::CFG_CODE_TOUCH: code_t_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // event classification
  logic        match_x, match_y, match_t, touch, down, change, push, full, empty;
  logic [15:0] sat, pos_x_new, pos_y_new;
  logic [IdxW-1:0] wr_next;
  tecq_pkg::kind_e kind;
  tecq_pkg::entry_t wentry;

  always_comb begin
    match_x = (item_q.code == code_x_q);
    match_y = (item_q.code == code_y_q);
    match_t = (item_q.code == code_t_q);
    if (item_q.value[31]) begin
      sat = '0;
    end else if (|item_q.value[30:16]) begin
      sat = tecq_pkg::COORD_MAX;
    end else begin
      sat = item_q.value[15:0];
    end
    pos_x_new = match_x ? sat : pos_x_q;
    pos_y_new = (!match_x && match_y) ? sat : pos_y_q;
    down    = |item_q.value;
    touch   = item_q.sync && match_t;
    change  = (down != pressed_q);
    push    = touch && (change || pressed_q);
    kind    = change ? (down ? tecq_pkg::KIND_PRESS : tecq_pkg::KIND_RELEASE)
                     : tecq_pkg::KIND_MOVE;
    wr_next = next_slot(wr_q);
    full    = (wr_next == rd_q);
    empty   = (wr_q == rd_q);
    wentry  = '{kind: kind, y: pos_y_new, x: pos_x_new};
  end

  // result word for an event or for a captured pop
  always_comb begin
    res_d = '0;
    if (!item_q.cmd) begin
      res_d.queued  = push;
      res_d.dropped = push && full;
    end else if (hit_q) begin
      res_d.out_valid = 1'b1;
      res_d.out_kind  = 2'(rdata_q.kind);
      res_d.out_x     = rdata_q.x;
      res_d.out_y     = rdata_q.y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      pressed_q <= 1'b0;
      wr_q      <= '0;
      rd_q      <= '0;
      hit_q     <= 1'b0;
    end else if (cmd_i.exec) begin
      if (item_q.cmd) begin
        hit_q <= !empty;
        if (!empty) begin
          rd_q <= next_slot(rd_q);
        end
      end else begin
        pos_x_q <= pos_x_new;
        pos_y_q <= pos_y_new;
        if (touch) begin
          pressed_q <= down;
        end
        if (push) begin
          wr_q <= wr_next;
          // overwrite the oldest entry when full
          if (full) begin
            rd_q <= next_slot(rd_q);
          end
        end
      end
    end
  end

  // payload registers and memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      rdata_q <= mem[rd_q];
      if (!item_q.cmd && push) begin
        mem[wr_q] <= wentry;
      end
    end
    if ((cmd_i.exec && !item_q.cmd) || cmd_i.capture) begin
      res_q <= res_d;
    end
  end

  assign status_o.is_pop = item_q.cmd;
  assign out_data_o      = res_q;

endmodule

`default_nettype wire

/* rtl/touch_event_classifier_queue.sv */
// top level of the touch event classifier queue
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_ready_o   tecq_pkg::in_item_t
// out      output     out_valid_o/out_ready_i tecq_pkg::out_item_t
// cfg      input      cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// one item at a time: an event result is registered in ST_EXEC, a pop result in ST_READ
// after the registered queue memory read; the result is then presented in ST_HOLD
// a new item is taken only in ST_IDLE, after the last result has been transferred
// reset clears positions, press flag, ring indexes and sets default codes; memory not cleared
// a stalled output holds the result and keeps in_ready_o low until transferred
`default_nettype none

module touch_event_classifier_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  tecq_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output tecq_pkg::out_item_t  out_data_o,
  input  wire                  cfg_we_i,
  input  wire  [1:0]           cfg_idx_i,
  input  wire  [15:0]          cfg_data_i
);

  tecq_pkg::ctrl_cmd_t  cmd;
  tecq_pkg::dp_status_t status;

  tecq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tecq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the touch event classifier queue
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tecq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned LONG_HOLD_CYCLES = 150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_CODE_POS_X;
  logic [15:0] cfg_data_i = '0;

  touch_event_classifier_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predicted block state
  logic [15:0] code_x_q = CODE_POS_X_RST;
  logic [15:0] code_y_q = CODE_POS_Y_RST;
  logic [15:0] code_touch_q = CODE_TOUCH_RST;
  logic [15:0] pos_x = '0;
  logic [15:0] pos_y = '0;
  logic        pressed = 1'b0;
  entry_t      ring_mem [QUEUE_DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_taken = 1'b0;
  bit          steady_tail = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic out_item_t classify_event(in_item_t it);
    out_item_t   r;
    kind_e       ev_kind;
    logic        down;
    int unsigned nxt;
    logic [15:0] sat;
    r = '0;
    if (it.cmd) begin
      if (wr_ptr != rd_ptr) begin
        r.out_valid = 1'b1;
        r.out_kind  = ring_mem[rd_ptr].kind;
        r.out_x     = ring_mem[rd_ptr].x;
        r.out_y     = ring_mem[rd_ptr].y;
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      end
      return r;
    end
    if (it.value < 0) sat = 16'd0;
    else if (it.value > 32'sd65535) sat = COORD_MAX;
    else sat = it.value[15:0];
    // x wins over y when both registers hold the same code
    if (it.code == code_x_q) pos_x = sat;
    else if (it.code == code_y_q) pos_y = sat;
    else if (it.code != code_touch_q) return r;
    if (!(it.sync && it.code == code_touch_q)) return r;
    down = (it.value != 0);
    if (down != pressed) begin
      pressed = down;
      ev_kind = down ? KIND_PRESS : KIND_RELEASE;
    end else if (pressed) begin
      ev_kind = KIND_MOVE;
    end else begin
      return r;
    end
    nxt = (wr_ptr + 1) % QUEUE_DEPTH;
    // ring keeps one slot free, so a full ring loses its oldest entry
    if (nxt == rd_ptr) begin
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      r.dropped = 1'b1;
    end
    ring_mem[wr_ptr].kind = ev_kind;
    ring_mem[wr_ptr].x    = pos_x;
    ring_mem[wr_ptr].y    = pos_y;
    wr_ptr = nxt;
    r.queued = 1'b1;
    return r;
  endfunction

  function automatic in_item_t make_item(logic cmd, logic [15:0] code,
                                         logic [31:0] value, logic sync);
    in_item_t it;
    it.cmd   = cmd;
    it.code  = code;
    it.value = value;
    it.sync  = sync;
    return it;
  endfunction

  function automatic logic [31:0] coord_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd65536;
      3: return 32'd65535;
      4: return 32'd0;
      5: return $urandom;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic in_item_t random_item(int unsigned pop_pct);
    in_item_t it;
    it.cmd   = 1'b0;
    it.code  = 16'($urandom);
    it.value = $urandom;
    it.sync  = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < pop_pct) begin
      it.cmd = 1'b1;
      return it;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        it.code  = code_x_q;
        it.value = coord_value();
      end
      3, 4: begin
        it.code  = code_y_q;
        it.value = coord_value();
      end
      5, 6, 7: begin
        it.code  = code_touch_q;
        it.sync  = 1'b1;
        it.value = ($urandom_range(0, 4) < 2) ? 32'd0 : $urandom;
      end
      8: begin
        it.code = code_touch_q;
        it.sync = 1'b0;
      end
      default: ;  // random code, mostly ignored
    endcase
    return it;
  endfunction

  function automatic void check_field(string field, logic [31:0] want_v,
                                      logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, field, want_v, got_v);
    end
  endfunction

  task automatic set_codes(logic [15:0] cx, logic [15:0] cy, logic [15:0] ct);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CODE_POS_X;
    cfg_data_i <= cx;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CODE_POS_Y;
    cfg_data_i <= cy;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CODE_TOUCH;
    cfg_data_i <= ct;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    code_x_q     = cx;
    code_y_q     = cy;
    code_touch_q = ct;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    // an ignored item may still be in flight inside the block
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n, int unsigned pop_pct);
    repeat (n) pending_items.push_back(random_item(pop_pct));
    wait_drained();
  endtask

  // sender: presents queued items, predicts each one at its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(classify_event(in_data_i));
        void'(pending_items.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // item stays on the bus until transfer
      end else if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
        send_gap   <= $urandom_range(0, 11);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items[0];
      end
    end
  end

  // receiver: checks each result transfer and drives backpressure
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i     <= 1'b0;
      stall_left      <= 0;
      long_hold_taken <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        end else begin
          want = expected_results.pop_front();
          check_field("queued", 32'(want.queued), 32'(out_data_o.queued));
          check_field("dropped", 32'(want.dropped), 32'(out_data_o.dropped));
          check_field("out_valid", 32'(want.out_valid), 32'(out_data_o.out_valid));
          check_field("out_kind", 32'(want.out_kind), 32'(out_data_o.out_kind));
          check_field("out_x", 32'(want.out_x), 32'(out_data_o.out_x));
          check_field("out_y", 32'(want.out_y), 32'(out_data_o.out_y));
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken <= 1'b1;
        stall_left      <= LONG_HOLD_CYCLES;
        out_ready_i     <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= (stall_left == 1);
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        stall_left  <= $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset codes: x 0, y 1, touch 330
    pending_items.push_back(make_item(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd0, 32'h8000_0000, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd1, 32'h7FFF_FFFF, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd0, 32'd65536, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd0, 32'd65535, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd1, 32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd1, 32'd4660, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd330, 32'd1, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd330, 32'd0, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd330, 32'd1, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd330, 32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd0, 32'd100, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd330, 32'h8000_0000, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd330, 32'd0, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'hFFFF, 32'd5, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'd2, 32'd0, 1'b0));
    repeat (5) pending_items.push_back(make_item(1'b1, 16'd0, 32'd0, 1'b0));
    wait_drained();

    // all three registers on one code
    set_codes(16'hFFFF, 16'hFFFF, 16'hFFFF);
    pending_items.push_back(make_item(1'b0, 16'hFFFF, 32'd5, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'hFFFF, 32'd0, 1'b1));
    pending_items.push_back(make_item(1'b0, 16'hFFFF, 32'd70000, 1'b0));
    pending_items.push_back(make_item(1'b0, 16'd0, 32'd9, 1'b1));
    repeat (3) pending_items.push_back(make_item(1'b1, 16'd0, 32'd0, 1'b0));
    wait_drained();

    set_codes(CODE_POS_X_RST, CODE_POS_Y_RST, CODE_TOUCH_RST);
    random_phase(65, 30);

    // few pops so the ring overflows
    set_codes(16'hFFFF, 16'h0000, 16'h8000);
    random_phase(65, 5);

    set_codes(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    long_hold_req = 1'b1;
    random_phase(65, 45);

    // x and touch share a code
    set_codes(16'h1234, 16'h4321, 16'h1234);
    random_phase(65, 30);

    set_codes(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    random_phase(65, 60);

    // y and touch share a code, full rate on both sides
    set_codes(16'h0007, 16'h00FF, 16'h00FF);
    steady_tail = 1'b1;
    random_phase(65, 25);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
